// ===== src/qeb_pkg.sv =====
`default_nettype none

package qeb_pkg;

    localparam int COUNT_W = 5;
    localparam int THR_W   = 3;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 3'd3;
    localparam logic [1:0]       PHASE_RESET     = 2'b11;

    localparam logic signed [1:0] STEP_NONE = 2'sd0;
    localparam logic signed [1:0] STEP_INC  = 2'sd1;
    localparam logic signed [1:0] STEP_DEC  = -2'sd1;

    localparam logic SEL_RIGHT = 1'b0;
    localparam logic SEL_LEFT  = 1'b1;

    typedef struct packed {
        logic       right_button;
        logic       left_button;
        logic [1:0] right_ab;
        logic [1:0] left_ab;
        logic       active_encoder;
    } t_in_item;

    typedef struct packed {
        logic right_click;
        logic left_click;
        logic right_up;
        logic right_down;
        logic left_up;
        logic left_down;
    } t_out_item;

    typedef struct packed {
        logic up;
        logic down;
    } t_step;

    // quadrature transition table, index is {previous ab, current ab}
    function automatic logic signed [1:0] step_lookup(input logic [3:0] idx);
        logic signed [1:0] v;
        case (idx)
            4'd0:    v = STEP_NONE;
            4'd1:    v = STEP_DEC;
            4'd2:    v = STEP_INC;
            4'd3:    v = STEP_NONE;
            4'd4:    v = STEP_INC;
            4'd5:    v = STEP_NONE;
            4'd6:    v = STEP_NONE;
            4'd7:    v = STEP_DEC;
            4'd8:    v = STEP_DEC;
            4'd9:    v = STEP_NONE;
            4'd10:   v = STEP_NONE;
            4'd11:   v = STEP_INC;
            4'd12:   v = STEP_NONE;
            4'd13:   v = STEP_INC;
            4'd14:   v = STEP_DEC;
            4'd15:   v = STEP_NONE;
            default: v = STEP_NONE;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/qeb_button.sv =====
`default_nettype none

module qeb_button (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_level,
    output logic      o_click
);

    logic r_armed;
    logic n_armed;

    always_comb begin
        n_armed = r_armed;
        o_click = 1'b0;
        if (i_level) begin
            if (r_armed) begin
                o_click = 1'b1;
                n_armed = 1'b0;
            end
        end else begin
            n_armed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
        end else if (i_en) begin
            r_armed <= n_armed;
        end
    end

    a_click_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_click) |=> !r_armed)
        else $error("button still armed after click");

endmodule

`default_nettype wire

// ===== src/qeb_encoder.sv =====
`default_nettype none

module qeb_encoder (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic [1:0]                  i_ab,
    input  wire logic [qeb_pkg::THR_W-1:0]   i_threshold,
    output qeb_pkg::t_step                   o_step
);

    logic [1:0]                          r_prev;
    logic signed [qeb_pkg::COUNT_W-1:0]  r_count;
    logic signed [qeb_pkg::COUNT_W-1:0]  n_count;
    logic signed [1:0]                   w_delta;
    logic signed [qeb_pkg::COUNT_W-1:0]  w_sum;
    logic signed [qeb_pkg::COUNT_W-1:0]  w_thr;
    logic signed [qeb_pkg::COUNT_W-1:0]  w_neg_thr;

    always_comb begin
        w_delta   = qeb_pkg::step_lookup({r_prev, i_ab});
        w_sum     = r_count + qeb_pkg::COUNT_W'(w_delta);
        w_thr     = $signed({{(qeb_pkg::COUNT_W-qeb_pkg::THR_W){1'b0}}, i_threshold});
        w_neg_thr = -w_thr;
        o_step    = '0;
        n_count   = w_sum;
        if (w_sum > w_thr) begin
            o_step.up = 1'b1;
            n_count   = '0;
        end else if (w_sum < w_neg_thr) begin
            o_step.down = 1'b1;
            n_count     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= qeb_pkg::PHASE_RESET;
            r_count <= '0;
        end else if (i_en) begin
            r_prev  <= i_ab;
            r_count <= n_count;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= -5'sd8) && (r_count <= 5'sd8))
        else $error("encoder count out of range");

    a_step_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && (o_step.up || o_step.down)) |=> (r_count == '0))
        else $error("count not cleared after step");

endmodule

`default_nettype wire

// ===== src/quadrature_encoder_with_buttons_core.sv =====
// channel   direction   signals                               transaction when
// in        input       i_in_valid, o_in_ready, i_in_data     i_in_valid && o_in_ready
// out       output      o_out_valid, i_out_ready, o_out_data  o_out_valid && i_out_ready
// cfg       input       i_cfg_we, i_cfg_wdata                 i_cfg_we
//
// one item per cycle sustained while results are taken; an input passes through
// the input register, then is decoded into the result register
// reset is synchronous and active low; buttons start disarmed, phases at 3, counts 0
// a stalled result holds its register; the input register still drains into
// it when the result is taken in the same cycle
`default_nettype none

module quadrature_encoder_with_buttons_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire qeb_pkg::t_in_item           i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output qeb_pkg::t_out_item               o_out_data,
    input  wire logic                        i_cfg_we,
    input  wire logic [qeb_pkg::THR_W-1:0]   i_cfg_wdata
);

    logic                       r_in_valid;
    qeb_pkg::t_in_item          r_in;
    logic                       r_out_valid;
    qeb_pkg::t_out_item         r_out;
    qeb_pkg::t_out_item         n_out;
    logic [qeb_pkg::THR_W-1:0]  r_threshold;
    logic                       w_adv;
    logic                       w_right_en;
    logic                       w_left_en;
    logic                       w_right_click;
    logic                       w_left_click;
    qeb_pkg::t_step             w_right_step;
    qeb_pkg::t_step             w_left_step;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_right_en = w_adv && (r_in.active_encoder == qeb_pkg::SEL_RIGHT);
    assign w_left_en  = w_adv && (r_in.active_encoder == qeb_pkg::SEL_LEFT);

    qeb_button u_right_button (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_level (r_in.right_button),
        .o_click (w_right_click)
    );

    qeb_button u_left_button (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_level (r_in.left_button),
        .o_click (w_left_click)
    );

    qeb_encoder u_right_enc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_right_en),
        .i_ab        (r_in.right_ab),
        .i_threshold (r_threshold),
        .o_step      (w_right_step)
    );

    qeb_encoder u_left_enc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_left_en),
        .i_ab        (r_in.left_ab),
        .i_threshold (r_threshold),
        .o_step      (w_left_step)
    );

    always_comb begin
        n_out             = '0;
        n_out.right_click = w_right_click;
        n_out.left_click  = w_left_click;
        if (r_in.active_encoder == qeb_pkg::SEL_RIGHT) begin
            n_out.right_up   = w_right_step.up;
            n_out.right_down = w_right_step.down;
        end else begin
            n_out.left_up   = w_left_step.up;
            n_out.left_down = w_left_step.down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= qeb_pkg::THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_one_encoder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !((r_out.right_up || r_out.right_down)
                          && (r_out.left_up || r_out.left_down)))
        else $error("both encoders stepped in one transaction");

    a_no_up_and_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.right_up && r_out.right_down)
                        && !(r_out.left_up && r_out.left_down))
        else $error("up and down in one transaction");

endmodule

`default_nettype wire

// ===== tb/tb_quadrature_encoder_with_buttons_core.sv =====
`timescale 1ns / 1ps

module tb_quadrature_encoder_with_buttons_core;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 60;
    localparam int MAX_REPORTS    = 50;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    qeb_pkg::t_in_item          in_data   = '0;
    logic                       out_ready = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [qeb_pkg::THR_W-1:0]  cfg_wdata = '0;
    logic                       o_in_ready;
    logic                       o_out_valid;
    qeb_pkg::t_out_item         o_out_data;

    // decoder mirror: index 0 is the right encoder/button, 1 the left
    logic [qeb_pkg::THR_W-1:0]  thr_m;
    logic [1:0]                 phase_m [2];
    logic signed [4:0]          count_m [2];
    logic                       armed_m [2];
    int quad_delta [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

    qeb_pkg::t_out_item pending_pulses [$];
    qeb_pkg::t_out_item want;

    int fail_count    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    // stimulus shaping
    int         run_left  = 0;
    bit         run_sel   = 1'b0;
    bit         run_up    = 1'b1;
    logic [1:0] btn_level = 2'b00;

    quadrature_encoder_with_buttons_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void reset_mirror();
        thr_m = qeb_pkg::THRESHOLD_RESET;
        for (int i = 0; i < 2; i++) begin
            phase_m[i] = qeb_pkg::PHASE_RESET;
            count_m[i] = '0;
            armed_m[i] = 1'b0;
        end
    endfunction

    function automatic qeb_pkg::t_out_item decode_event(input qeb_pkg::t_in_item ev);
        qeb_pkg::t_out_item  r;
        int                  sel;
        int                  c;
        logic [1:0]          cur;
        r = '0;
        r.right_click = ev.right_button & armed_m[0];
        armed_m[0] = ~ev.right_button;
        r.left_click = ev.left_button & armed_m[1];
        armed_m[1] = ~ev.left_button;
        sel = (ev.active_encoder == qeb_pkg::SEL_LEFT) ? 1 : 0;
        cur = (sel == 1) ? ev.left_ab : ev.right_ab;
        c = int'(count_m[sel]) + quad_delta[{phase_m[sel], cur}];
        phase_m[sel] = cur;
        if (c > int'(thr_m)) begin
            c = 0;
            if (sel == 1) r.left_up = 1'b1;
            else r.right_up = 1'b1;
        end else if (c < -int'(thr_m)) begin
            c = 0;
            if (sel == 1) r.left_down = 1'b1;
            else r.right_down = 1'b1;
        end
        count_m[sel] = c[4:0];
        return r;
    endfunction

    // gray code walk: up goes 0 2 3 1 0
    function automatic logic [1:0] rotate(input logic [1:0] ab, input bit up);
        case (ab)
            2'd0:    return up ? 2'd2 : 2'd1;
            2'd2:    return up ? 2'd3 : 2'd0;
            2'd3:    return up ? 2'd1 : 2'd2;
            default: return up ? 2'd0 : 2'd3;
        endcase
    endfunction

    function automatic qeb_pkg::t_in_item random_event();
        qeb_pkg::t_in_item ev;
        if (run_left == 0) begin
            run_left = $urandom_range(12, 1);
            run_sel  = 1'($urandom_range(1));
            run_up   = 1'($urandom_range(1));
        end
        run_left--;
        if ($urandom_range(99) < 30) btn_level[0] = ~btn_level[0];
        if ($urandom_range(99) < 30) btn_level[1] = ~btn_level[1];
        ev.right_button   = btn_level[0];
        ev.left_button    = btn_level[1];
        ev.right_ab       = 2'($urandom_range(3));
        ev.left_ab        = 2'($urandom_range(3));
        ev.active_encoder = run_sel ? qeb_pkg::SEL_LEFT : qeb_pkg::SEL_RIGHT;
        // mostly clean rotation, otherwise noise on the decoded pins
        if ($urandom_range(99) < 85) begin
            if (run_sel) ev.left_ab = rotate(phase_m[1], run_up);
            else ev.right_ab = rotate(phase_m[0], run_up);
        end
        return ev;
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_bit(input string name, input logic got, input logic exp);
        if (got !== exp) report_mismatch($sformatf("%s got %b expected %b", name, got, exp));
    endtask

    task automatic send_event(input qeb_pkg::t_in_item ev);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(4, 1);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do @(posedge clk); while (!o_in_ready);
        pending_pulses.push_back(decode_event(ev));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_pulses.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_step_threshold(input logic [qeb_pkg::THR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        thr_m = value;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct    <= recv_pct;
    endtask

    // all sixteen phase transitions on the right encoder, buttons through
    // every arm and press combination, then one detent each way on the left
    task automatic test_directed();
        logic [1:0] walk [17] = '{0, 0, 1, 0, 2, 0, 3, 1, 1, 2, 1, 3, 2, 2, 3, 3, 0};
        logic [1:0] btns [17] = '{3, 0, 3, 3, 1, 2, 1, 0, 2, 2, 0, 1, 3, 0, 0, 3, 3};
        qeb_pkg::t_in_item ev;
        for (int i = 0; i < 17; i++) begin
            ev.right_button   = btns[i][1];
            ev.left_button    = btns[i][0];
            ev.right_ab       = walk[i];
            ev.left_ab        = 2'($urandom_range(3));
            ev.active_encoder = qeb_pkg::SEL_RIGHT;
            send_event(ev);
        end
        for (int i = 0; i < 8; i++) begin
            ev.right_button   = 1'b0;
            ev.left_button    = 1'b0;
            ev.right_ab       = 2'($urandom_range(3));
            ev.left_ab        = rotate(phase_m[1], i < 4);
            ev.active_encoder = qeb_pkg::SEL_LEFT;
            send_event(ev);
        end
        wait_for_results();
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input logic [qeb_pkg::THR_W-1:0] thr, input int n);
        wait_for_results();
        set_idling(send_pct, recv_pct);
        write_step_threshold(thr);
        repeat (n) send_event(random_event());
        wait_for_results();
    endtask

    // receiver stops for a long stretch while events keep coming
    task automatic test_backpressure();
        wait_for_results();
        set_idling(0, 0);
        write_step_threshold(3'd2);
        hold_req <= hold_req + 1;
        repeat (40) send_event(random_event());
        wait_for_results();
    endtask

    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_pulses.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = pending_pulses.pop_front();
                check_bit("right_click", o_out_data.right_click, want.right_click);
                check_bit("left_click", o_out_data.left_click, want.left_click);
                check_bit("right_up", o_out_data.right_up, want.right_up);
                check_bit("right_down", o_out_data.right_down, want.right_down);
                check_bit("left_up", o_out_data.left_up, want.left_up);
                check_bit("left_down", o_out_data.left_down, want.left_down);
            end
        end
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_quadrature_encoder_with_buttons_core NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        reset_mirror();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(0, 0, 3'd7, 170);
        test_random_phase(61, 0, 3'd0, 170);
        test_random_phase(0, 61, 3'd1, 170);
        test_random_phase(19, 19, 3'd5, 170);
        test_backpressure();

        wait_for_results();
        if (fail_count == 0 && pending_pulses.size() == 0) begin
            $display("tb_quadrature_encoder_with_buttons_core OK");
        end else begin
            $display("tb_quadrature_encoder_with_buttons_core NOT OK");
        end
        $finish;
    end

endmodule
